// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros shared by the ocv soc estimator rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define OSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define OSE_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define OSE_ASSERT(lbl, prop, msg)
`define OSE_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/core/ose_pkg.sv
// ---------------------------------------------------------------------------
// ose_pkg
// shared types, constants and helpers of the ocv soc estimator
// ---------------------------------------------------------------------------
package ose_pkg;

	localparam int TABLE_ENTRIES_DEF = 101;
	localparam int QUEUE_DEPTH       = 2;
	localparam int QUEUE_PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int MV_W   = 16;
	localparam int IDX_IN_W = 7;
	localparam int RES_W  = 8;
	localparam int SOC_W  = 7;
	localparam int RAW_W  = 9;

	localparam logic [RES_W-1:0] RES_RESET = 8'd5;
	localparam logic [SOC_W-1:0] SOC_MAX   = 7'd100;
	localparam logic [7:0]       ADD_SAT   = 8'd255;

	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_ESTIMATE = 1'b1;

	// request travelling from the front end to the back end
	typedef struct packed {
		logic                op;
		logic [IDX_IN_W-1:0] entry_index;
		logic [MV_W-1:0]     data;
	} cmd_t;

	// back end status seen by the top level
	typedef struct packed {
		logic             idle;
		logic [SOC_W-1:0] last_soc;
	} bk_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_X1,
		BK_PREP,
		BK_DIV,
		BK_LIMIT,
		BK_DONE
	} bk_state_t;

	function automatic logic [SOC_W-1:0] cap_soc(input logic [RAW_W-1:0] v);
		logic [SOC_W-1:0] r;
		if (v > RAW_W'(SOC_MAX)) begin
			r = SOC_MAX;
		end else begin
			r = v[SOC_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/ose_front.sv
// ---------------------------------------------------------------------------
// ose_front
// accepts requests, holds the resistance register and forms the ocv
// ---------------------------------------------------------------------------
module ose_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ose_pkg::RES_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [ose_pkg::IDX_IN_W-1:0]     entry_index,
	input  logic [ose_pkg::MV_W-1:0]         entry_voltage_mv,
	input  logic [ose_pkg::MV_W-1:0]         terminal_voltage_mv,
	input  logic signed [ose_pkg::MV_W-1:0]  cell_current,
	output logic                             cmd_valid,
	input  logic                             cmd_ready,
	output ose_pkg::cmd_t                    cmd
);
	import ose_pkg::*;

	logic [RES_W-1:0]    res_q;
	logic                valid_s1;
	logic                op_s1;
	logic [IDX_IN_W-1:0] idx_s1;
	logic [MV_W-1:0]     data_s1;
	logic signed [24:0]  prod_s1;
	logic signed [25:0]  sum;
	logic [MV_W-1:0]     ocv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
		end else if (cfg_we) begin
			res_q <= cfg_wdata;
		end
	end

	assign in_ready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// current times resistance, registered before the add
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			idx_s1  <= entry_index;
			data_s1 <= (operation == OP_ESTIMATE) ? terminal_voltage_mv : entry_voltage_mv;
			prod_s1 <= cell_current * $signed({1'b0, res_q});
		end
	end

	// saturate to the millivolt range
	always_comb begin
		sum = $signed({10'b0, data_s1}) + $signed({prod_s1[24], prod_s1});
		if (sum[25]) begin
			ocv = '0;
		end else if (sum[24:16] != 9'd0) begin
			ocv = '1;
		end else begin
			ocv = sum[15:0];
		end
	end

	assign cmd_valid       = valid_s1;
	assign cmd.op          = op_s1;
	assign cmd.entry_index = idx_s1;
	assign cmd.data        = (op_s1 == OP_ESTIMATE) ? ocv : data_s1;

endmodule

// File: rtl/core/ose_queue.sv
// ---------------------------------------------------------------------------
// ose_queue
// short request queue between the front end and the back end
// ---------------------------------------------------------------------------
module ose_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push_valid,
	output logic                               push_ready,
	input  ose_pkg::cmd_t                      push_data,
	output logic                               pop_valid,
	input  logic                               pop_ready,
	output ose_pkg::cmd_t                      pop_data,
	output logic [ose_pkg::QUEUE_CNT_W-1:0]    count
);
	import ose_pkg::*;

	cmd_t                   slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic                   push;
	logic                   pop;

	assign push_ready = cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];
	assign count      = cnt_q;

	function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
		logic [QUEUE_PTR_W-1:0] r;
		if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/ose_back.sv
// ---------------------------------------------------------------------------
// ose_back
// table store, nearest-entry scan, serial divide and result register
// ---------------------------------------------------------------------------
module ose_back #(
	parameter int TABLE_ENTRIES = ose_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  ose_pkg::cmd_t                  cmd,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ose_pkg::SOC_W-1:0]      soc_percent,
	output logic [ose_pkg::MV_W-1:0]       ocv_mv,
	output logic                           exact_hit,
	output ose_pkg::bk_status_t            status
);
	import ose_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	bk_state_t state_q, state_d;

	logic [MV_W-1:0]   tbl_mem [TABLE_ENTRIES];
	logic [MV_W-1:0]   rd_data_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;

	logic [MV_W-1:0]   ocv_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  best_q;
	logic [MV_W:0]     best_diff_q;
	logic [MV_W-1:0]   best_val_q;
	logic signed [MV_W:0] num_q;
	logic signed [MV_W:0] den_q;
	logic [MV_W-1:0]   rem_q;
	logic [27:0]       dsh_q;
	logic [7:0]        quo_q;
	logic [3:0]        div_cnt_q;
	logic [RAW_W-1:0]  r_q;
	logic [SOC_W-1:0]  last_soc_q;
	logic [SOC_W-1:0]  res_soc_q;
	logic              res_hit_q;
	logic              out_valid_q;

	logic [MV_W-1:0]   diff;
	logic              hit;
	logic              closer;
	logic [IDX_W-1:0]  best_nx;
	logic [MV_W-1:0]   best_val_nx;
	logic              at_last;
	logic              below_last;
	logic              in_range;
	logic [IDX_W-1:0]  y0;
	logic [IDX_W-1:0]  y1;
	logic [MV_W:0]     num_neg;
	logic [MV_W:0]     den_neg;
	logic [MV_W-1:0]   an;
	logic [MV_W-1:0]   ad;
	logic [19:0]       dvsr;
	logic              ge;
	logic [RAW_W-1:0]  lim;
	logic              out_load;

	// scan compare on the entry read last cycle, plus divide, limit and output helpers
	always_comb begin
		diff        = (rd_data_q >= ocv_q) ? rd_data_q - ocv_q : ocv_q - rd_data_q;
		hit         = diff == '0;
		closer      = {1'b0, diff} < best_diff_q;
		best_nx     = closer ? ptr_q : best_q;
		best_val_nx = closer ? rd_data_q : best_val_q;
		at_last     = ptr_q == LAST_IDX;
		below_last  = ocv_q < rd_data_q;
		in_range    = 9'(cmd.entry_index) < 9'(TABLE_ENTRIES);
		y0          = LAST_IDX - best_q;
		y1          = y0 - 1'b1;
		num_neg     = -num_q;
		den_neg     = -den_q;
		an          = num_q[MV_W] ? num_neg[MV_W-1:0] : num_q[MV_W-1:0];
		ad          = den_q[MV_W] ? den_neg[MV_W-1:0] : den_q[MV_W-1:0];
		dvsr        = {1'b0, ad, 3'b0} + {3'b0, ad, 1'b0};
		ge          = {12'b0, rem_q} >= dsh_q;
		lim         = (r_q < RAW_W'(last_soc_q)) ? r_q : RAW_W'(last_soc_q);
		out_load    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (cmd.op == OP_ESTIMATE) begin
						rd_en   = 1'b1;
						state_d = BK_SCAN;
					end else begin
						wr_en   = in_range;
						state_d = BK_DONE;
					end
				end
			end
			BK_SCAN: begin
				if (hit) begin
					state_d = BK_DONE;
				end else if (at_last) begin
					if (below_last) begin
						state_d = BK_DONE;
					end else if (best_nx == LAST_IDX) begin
						state_d = BK_LIMIT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = best_nx + 1'b1;
						state_d = BK_X1;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + 1'b1;
				end
			end
			BK_X1: begin
				state_d = BK_PREP;
			end
			BK_PREP: begin
				if (num_q == '0 || den_q == '0 || num_q[MV_W] == den_q[MV_W]) begin
					state_d = BK_LIMIT;
				end else begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if ((div_cnt_q == 4'd0 && ge) || div_cnt_q == 4'd8) begin
					state_d = BK_LIMIT;
				end
			end
			BK_LIMIT: begin
				state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_load) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[IDX_W'(cmd.entry_index)] <= cmd.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= tbl_mem[rd_addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				ptr_q       <= '0;
				best_q      <= '0;
				best_diff_q <= {1'b1, {MV_W{1'b0}}};
				res_hit_q   <= 1'b0;
				res_soc_q   <= '0;
				ocv_q       <= (cmd.op == OP_ESTIMATE) ? cmd.data : '0;
			end
			BK_SCAN: begin
				ptr_q       <= ptr_q + 1'b1;
				best_diff_q <= closer ? {1'b0, diff} : best_diff_q;
				best_q      <= best_nx;
				best_val_q  <= best_val_nx;
				if (hit) begin
					res_soc_q <= cap_soc(RAW_W'(LAST_IDX - ptr_q));
					res_hit_q <= 1'b1;
				end
				// nearest entry at the end of the table interpolates to zero
				r_q <= '0;
			end
			BK_X1: begin
				num_q <= $signed({1'b0, best_val_q}) - $signed({1'b0, ocv_q});
				den_q <= $signed({1'b0, best_val_q}) - $signed({1'b0, rd_data_q});
			end
			BK_PREP: begin
				rem_q     <= an;
				dsh_q     <= {dvsr, 8'b0};
				quo_q     <= '0;
				div_cnt_q <= '0;
				if (num_q == '0) begin
					r_q <= RAW_W'(y0);
				end else if (den_q == '0) begin
					// flat segment: below the entry steps down, above it is unbounded
					r_q <= num_q[MV_W] ? RAW_W'(y0) + RAW_W'(ADD_SAT) : RAW_W'(y1);
				end else begin
					r_q <= RAW_W'(y1);
				end
			end
			BK_DIV: begin
				dsh_q     <= dsh_q >> 1;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == 4'd0) begin
					if (ge) begin
						r_q <= RAW_W'(y0) + RAW_W'(ADD_SAT);
					end
				end else begin
					if (ge) begin
						rem_q <= rem_q - dsh_q[MV_W-1:0];
					end
					quo_q <= {quo_q[6:0], ge};
					r_q   <= RAW_W'(y0) + RAW_W'({quo_q[6:0], ge});
				end
			end
			BK_LIMIT: begin
				res_soc_q <= cap_soc(lim);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_soc_q <= SOC_MAX;
		end else if (state_q == BK_LIMIT) begin
			last_soc_q <= cap_soc(lim);
		end
	end

	// result register, parts the scan from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BK_DONE && out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_DONE && out_load) begin
			soc_percent <= res_soc_q;
			ocv_mv      <= ocv_q;
			exact_hit   <= res_hit_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.idle     = state_q == BK_IDLE;
	assign status.last_soc = last_soc_q;

endmodule

// File: rtl/core/ocv_soc_table_estimator_top.sv
// ---------------------------------------------------------------------------
// ocv_soc_table_estimator_top
// open-circuit voltage state-of-charge estimator with table interpolation
// ---------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        sink       in_valid / in_ready       operation, entry_index,
//                                                entry_voltage_mv,
//                                                terminal_voltage_mv, cell_current
// out       source     out_valid / out_ready     soc_percent, ocv_mv, exact_hit
// cfg       sink       cfg_we (no wait)          cfg_wdata -> series resistance
//
// a load request passes the front stage register, the queue and the back end done state before its result is registered
// for an estimate the table memory has one read port and the scan reads one
// entry per cycle, then the neighbour read, classification and a nine-step
// restoring divide follow
// reset needs no clearing pass; table entries are undefined until loaded
// the two-entry queue and the result register let input and output stall apart
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ocv_soc_table_estimator_top #(
	parameter int TABLE_ENTRIES = ose_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ose_pkg::RES_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [ose_pkg::IDX_IN_W-1:0]     entry_index,
	input  logic [ose_pkg::MV_W-1:0]         entry_voltage_mv,
	input  logic [ose_pkg::MV_W-1:0]         terminal_voltage_mv,
	input  logic signed [ose_pkg::MV_W-1:0]  cell_current,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ose_pkg::SOC_W-1:0]        soc_percent,
	output logic [ose_pkg::MV_W-1:0]         ocv_mv,
	output logic                             exact_hit
);
	import ose_pkg::*;

	// front end to queue
	logic       fq_valid;
	logic       fq_ready;
	cmd_t       fq_cmd;

	// queue to back end
	logic       qb_valid;
	logic       qb_ready;
	cmd_t       qb_cmd;
	logic [QUEUE_CNT_W-1:0] q_count;

	bk_status_t bk_stat;

	// queue full flag and stored soc limit, watched by the checks below
	logic             q_full;
	logic [SOC_W-1:0] soc_floor;

	// request intake, resistance register and ocv arithmetic
	ose_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (operation),
		.entry_index         (entry_index),
		.entry_voltage_mv    (entry_voltage_mv),
		.terminal_voltage_mv (terminal_voltage_mv),
		.cell_current        (cell_current),
		.cmd_valid           (fq_valid),
		.cmd_ready           (fq_ready),
		.cmd                 (fq_cmd)
	);

	// decouples intake from the long table scan
	ose_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_cmd),
		.count      (q_count)
	);

	// table store, scan, divide and the result register
	ose_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (qb_valid),
		.cmd_ready   (qb_ready),
		.cmd         (qb_cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.soc_percent (soc_percent),
		.ocv_mv      (ocv_mv),
		.exact_hit   (exact_hit),
		.status      (bk_stat)
	);

	assign q_full    = q_count == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign soc_floor = bk_stat.last_soc;

	// reported soc stays within percent range
	`OSE_ASSERT_NEVER(a_soc_range, out_valid && (soc_percent > SOC_MAX), "soc above range")

	// the stored soc limit only ever falls
	`OSE_ASSERT(a_last_soc_mono, 1'b1 |=> (soc_floor <= $past(soc_floor)), "last soc rose")

	// an idle back end drains a full queue straight away
	`OSE_ASSERT(a_queue_drain, (bk_stat.idle && q_full) |=> !q_full, "queue not drained")

endmodule
